/* rtl/spi_eep_pkg.sv */
package spi_eep_pkg;

    localparam int PAGE_SIZE_DEF    = 64;
    localparam int NUM_SECTIONS_DEF = 4;
    localparam int ADDR_BITS_DEF    = 16;
    localparam int NUM_SECT_REGS    = 4;
    localparam int QUEUE_DEPTH      = 4;

    localparam int CMD_W      = 3;
    localparam int SECT_W     = 3;
    localparam int IDX_W      = 16;
    localparam int CNT_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int ACTION_W   = 3;
    localparam int OPCODE_W   = 8;
    localparam int ADDR_OUT_W = 16;
    localparam int LEN_W      = 7;
    localparam int SPAN_W     = 17;
    localparam int SECT_REG_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PG_OFF_W   = 8;

    localparam logic [CMD_W-1:0] CMD_WRITE_OBJ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ_OBJ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_ITEMS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WREN       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRDI       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DONE       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CMD      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_HEADER   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DATA     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_COMPLETE = 3'd4;

    localparam logic [OPCODE_W-1:0] OP_NONE  = 8'h00;
    localparam logic [OPCODE_W-1:0] OP_WREN  = 8'h06;
    localparam logic [OPCODE_W-1:0] OP_WRDI  = 8'h04;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 8'h02;
    localparam logic [OPCODE_W-1:0] OP_READ  = 8'h03;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ADDR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_0 = 3'd1;

    localparam logic [SPAN_W-1:0] MAX_ADDR_RESET = 17'h10000;

    typedef enum logic [2:0] {
        KIND_BUSY,
        KIND_RANGE,
        KIND_REQUEST,
        KIND_WREN,
        KIND_WRDI,
        KIND_DONE
    } item_kind_t;

    typedef struct packed {
        item_kind_t          kind;
        logic                write_op;
        logic [SPAN_W-1:0]   addr;
        logic [SPAN_W-1:0]   rem;
        logic [PG_OFF_W-1:0] page_off;
    } front_item_t;

    typedef struct packed {
        logic [SPAN_W-1:0]                         max_addr;
        logic [NUM_SECT_REGS-1:0][SECT_REG_W-1:0] section;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        front_item_t item;
    } queue_head_t;

endpackage

/* rtl/spi_eep_front.sv */
module spi_eep_front
    import spi_eep_pkg::*;
#(
    parameter int PAGE_SIZE    = PAGE_SIZE_DEF,
    parameter int NUM_SECTIONS = NUM_SECTIONS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [SECT_W-1:0] section,
    input  logic [IDX_W-1:0]  index,
    input  logic [CNT_W-1:0]  count,
    input  logic              bus_idle,
    output logic              push,
    output front_item_t       push_item,
    input  logic              queue_full
);

    localparam int SEC_LIMIT   = (NUM_SECTIONS < NUM_SECT_REGS) ? NUM_SECTIONS : NUM_SECT_REGS;
    localparam int SEC_IDX_W   = $clog2(NUM_SECT_REGS);
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = RECIP_SHIFT - $clog2(PAGE_SIZE) + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / PAGE_SIZE);
    localparam logic [32:0] ADDR_SPAN = 33'd1 << ADDR_BITS;

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready;

    logic [CMD_W-1:0]  a_cmd_reg;
    logic              a_idle_reg;
    logic              a_sec_ok_reg;
    logic [15:0]       a_size_reg;
    logic [15:0]       a_base_reg;
    logic [31:0]       a_prod_addr_reg;
    logic [31:0]       a_prod_rem_reg;

    item_kind_t        b_kind_reg, b_kind_next;
    logic              b_write_reg;
    logic [SPAN_W-1:0] b_addr_reg;
    logic [SPAN_W-1:0] b_rem_reg;

    item_kind_t        c_kind_reg;
    logic              c_write_reg;
    logic [SPAN_W-1:0] c_addr_reg;
    logic [SPAN_W-1:0] c_rem_reg;
    logic [SPAN_W-1:0] c_q_reg, c_q_next;

    front_item_t       d_item_reg, d_item_next;

    logic [SEC_IDX_W-1:0]   sel;
    logic [SECT_REG_W-1:0]  sect_word;
    logic                   sec_ok;
    logic [31:0]            addr_full;
    logic [31:0]            rem_full;
    logic [32:0]            total;
    logic [32:0]            limit;
    logic [SPAN_W+RECIP_W-1:0] recip_prod;
    logic [SPAN_W-1:0]      q_times_page;
    logic [SPAN_W-1:0]      rem_raw;
    logic [SPAN_W-1:0]      page_rem;

    assign d_ready  = !d_valid_reg || !queue_full;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_stall = !a_ready;
    assign push      = d_valid_reg && !queue_full;
    assign push_item = d_item_reg;

    // stage A: pick section, form both products
    assign sec_ok    = ({1'b0, section} < 4'(SEC_LIMIT));
    assign sel       = section[SEC_IDX_W-1:0];
    assign sect_word = cfg.section[sel];

    // stage B: add, range check, classify
    assign addr_full = a_prod_addr_reg + {16'b0, a_base_reg};
    assign rem_full  = (a_cmd_reg == CMD_READ_ITEMS) ? a_prod_rem_reg : {16'b0, a_size_reg};
    assign total     = {1'b0, addr_full} + {1'b0, rem_full};
    assign limit     = ({16'b0, cfg.max_addr} < ADDR_SPAN) ? {16'b0, cfg.max_addr} : ADDR_SPAN;

    always_comb
    begin
        priority if (a_cmd_reg == CMD_WRITE_OBJ || a_cmd_reg == CMD_READ_OBJ ||
                     a_cmd_reg == CMD_READ_ITEMS)
        begin
            if (!a_idle_reg)
            begin
                b_kind_next = KIND_BUSY;
            end
            else if (!a_sec_ok_reg || total > limit)
            begin
                b_kind_next = KIND_RANGE;
            end
            else
            begin
                b_kind_next = KIND_REQUEST;
            end
        end
        else if (a_cmd_reg == CMD_WREN || a_cmd_reg == CMD_WRDI)
        begin
            if (!a_idle_reg)
            begin
                b_kind_next = KIND_BUSY;
            end
            else if (a_cmd_reg == CMD_WREN)
            begin
                b_kind_next = KIND_WREN;
            end
            else
            begin
                b_kind_next = KIND_WRDI;
            end
        end
        else if (a_cmd_reg == CMD_DONE)
        begin
            b_kind_next = KIND_DONE;
        end
        else
        begin
            b_kind_next = KIND_RANGE;
        end
    end

    // stage C: quotient by page size through the reciprocal
    assign recip_prod = b_addr_reg * RECIP;
    assign c_q_next   = SPAN_W'(recip_prod >> RECIP_SHIFT);

    // stage D: remainder with one correction step
    assign q_times_page = SPAN_W'(c_q_reg * SPAN_W'(PAGE_SIZE));
    assign rem_raw      = c_addr_reg - q_times_page;
    assign page_rem     = (rem_raw >= SPAN_W'(PAGE_SIZE)) ? rem_raw - SPAN_W'(PAGE_SIZE) : rem_raw;

    always_comb
    begin
        d_item_next.kind     = c_kind_reg;
        d_item_next.write_op = c_write_reg;
        d_item_next.addr     = c_addr_reg;
        d_item_next.rem      = c_rem_reg;
        d_item_next.page_off = page_rem[PG_OFF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_cmd_reg       <= command;
            a_idle_reg      <= bus_idle;
            a_sec_ok_reg    <= sec_ok;
            a_size_reg      <= sect_word[31:16];
            a_base_reg      <= sect_word[15:0];
            a_prod_addr_reg <= index * sect_word[31:16];
            a_prod_rem_reg  <= count * sect_word[31:16];
        end
        if (b_ready && a_valid_reg)
        begin
            b_kind_reg  <= b_kind_next;
            b_write_reg <= (a_cmd_reg == CMD_WRITE_OBJ);
            b_addr_reg  <= addr_full[SPAN_W-1:0];
            b_rem_reg   <= rem_full[SPAN_W-1:0];
        end
        if (c_ready && b_valid_reg)
        begin
            c_kind_reg  <= b_kind_reg;
            c_write_reg <= b_write_reg;
            c_addr_reg  <= b_addr_reg;
            c_rem_reg   <= b_rem_reg;
            c_q_reg     <= c_q_next;
        end
        if (d_ready && c_valid_reg)
        begin
            d_item_reg <= d_item_next;
        end
    end

endmodule

/* rtl/spi_eep_queue.sv */
module spi_eep_queue
    import spi_eep_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  front_item_t push_item,
    output logic        full,
    input  logic        pop,
    output queue_head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    front_item_t           slots_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign head.valid = (fill_reg != '0);
    assign head.item  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/spi_eep_back.sv */
module spi_eep_back
    import spi_eep_pkg::*;
#(
    parameter int PAGE_SIZE = PAGE_SIZE_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  queue_head_t           head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [ACTION_W-1:0]   action,
    output logic [OPCODE_W-1:0]   opcode,
    output logic [ADDR_OUT_W-1:0] address,
    output logic [LEN_W-1:0]      length,
    output logic [SPAN_W-1:0]     buffer_offset,
    output logic                  deselect_first
);

    localparam logic [ADDR_OUT_W-1:0] AMASK =
        (ADDR_BITS >= ADDR_OUT_W) ? {ADDR_OUT_W{1'b1}} :
        ADDR_OUT_W'((64'd1 << ADDR_BITS) - 64'd1);

    logic                  hp_reg, hp_next;
    logic                  wm_reg, wm_next;
    logic                  wl_reg, wl_next;
    logic [SPAN_W-1:0]     cur_reg, cur_next;
    logic [SPAN_W-1:0]     rem_reg, rem_next;
    logic [SPAN_W-1:0]     doff_reg, doff_next;
    logic [PG_OFF_W-1:0]   poff_reg, poff_next;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [ACTION_W-1:0]   action_reg, action_next;
    logic [OPCODE_W-1:0]   opcode_reg, opcode_next;
    logic [ADDR_OUT_W-1:0] address_reg, address_next;
    logic [LEN_W-1:0]      length_reg, length_next;
    logic [SPAN_W-1:0]     boff_reg, boff_next;
    logic                  desel_reg, desel_next;

    logic                  run_adv;
    logic                  hp_sel, wm_sel;
    logic [SPAN_W-1:0]     cur_sel, rem_sel, doff_sel;
    logic [PG_OFF_W-1:0]   poff_sel;
    logic [SPAN_W-1:0]     room;

    assign pop            = head.valid && (!out_valid_reg || !out_stall);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign action         = action_reg;
    assign opcode         = opcode_reg;
    assign address        = address_reg;
    assign length         = length_reg;
    assign buffer_offset  = boff_reg;
    assign deselect_first = desel_reg;

    always_comb
    begin
        run_adv  = 1'b0;
        hp_sel   = hp_reg;
        wm_sel   = wm_reg;
        cur_sel  = cur_reg;
        rem_sel  = rem_reg;
        doff_sel = doff_reg;
        poff_sel = poff_reg;
        wl_next  = wl_reg;
        status_next  = ST_OK;
        action_next  = ACT_NONE;
        opcode_next  = OP_NONE;
        address_next = '0;
        length_next  = '0;
        boff_next    = '0;
        desel_next   = 1'b0;
        unique case (head.item.kind)
            KIND_BUSY:
            begin
                status_next = ST_BUSY;
            end
            KIND_RANGE:
            begin
                status_next = ST_RANGE;
            end
            KIND_WREN:
            begin
                wl_next     = 1'b1;
                action_next = ACT_CMD;
                opcode_next = OP_WREN;
            end
            KIND_WRDI:
            begin
                wl_next     = 1'b0;
                action_next = ACT_CMD;
                opcode_next = OP_WRDI;
            end
            KIND_REQUEST:
            begin
                hp_sel   = 1'b1;
                wm_sel   = head.item.write_op;
                cur_sel  = head.item.addr;
                rem_sel  = head.item.rem;
                doff_sel = '0;
                poff_sel = head.item.page_off;
                run_adv  = 1'b1;
            end
            KIND_DONE:
            begin
                if (rem_reg == '0)
                begin
                    action_next = ACT_COMPLETE;
                    desel_next  = 1'b1;
                end
                else
                begin
                    run_adv = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase

        hp_next   = hp_sel;
        wm_next   = wm_sel;
        cur_next  = cur_sel;
        rem_next  = rem_sel;
        doff_next = doff_sel;
        poff_next = poff_sel;
        room      = SPAN_W'(PAGE_SIZE) - SPAN_W'(poff_sel);

        if (run_adv)
        begin
            if (hp_sel)
            begin
                desel_next = 1'b1;
                if (!wm_sel || wl_reg)
                begin
                    hp_next      = 1'b0;
                    wl_next      = 1'b0;
                    action_next  = ACT_HEADER;
                    opcode_next  = wm_sel ? OP_WRITE : OP_READ;
                    address_next = cur_sel[ADDR_OUT_W-1:0] & AMASK;
                end
                else
                begin
                    wl_next     = 1'b1;
                    action_next = ACT_CMD;
                    opcode_next = OP_WREN;
                end
            end
            else
            begin
                hp_next     = 1'b1;
                action_next = ACT_DATA;
                boff_next   = doff_sel;
                if (rem_sel > room)
                begin
                    rem_next    = rem_sel - room;
                    doff_next   = doff_sel + room;
                    cur_next    = cur_sel + room;
                    poff_next   = '0;
                    wl_next     = !wm_sel;
                    length_next = room[LEN_W-1:0];
                end
                else
                begin
                    rem_next    = '0;
                    length_next = rem_sel[LEN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg        <= 1'b1;
            wm_reg        <= 1'b0;
            wl_reg        <= 1'b0;
            cur_reg       <= '0;
            rem_reg       <= '0;
            doff_reg      <= '0;
            poff_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                hp_reg   <= hp_next;
                wm_reg   <= wm_next;
                wl_reg   <= wl_next;
                cur_reg  <= cur_next;
                rem_reg  <= rem_next;
                doff_reg <= doff_next;
                poff_reg <= poff_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg  <= status_next;
            action_reg  <= action_next;
            opcode_reg  <= opcode_next;
            address_reg <= address_next;
            length_reg  <= length_next;
            boff_reg    <= boff_next;
            desel_reg   <= desel_next;
        end
    end

endmodule

/* rtl/spi_eeprom_transfer_sequencer.sv */
// channel   handshake              payload
// cfg       cfg_we                 cfg_index, cfg_data
// in        in_valid / in_stall    command, section, index, count, bus_idle
// out       out_valid / out_stall  status, action, opcode, address, length,
//                                  buffer_offset, deselect_first
//
// One transaction accepted per cycle while in_stall is low; a result passes through
// four front stages, the queue and the output register.
// The back end retires one queued item per cycle unless out_stall holds the output; its state update sets the rate.
// rst_n clears all control state at once; no clearing pass.
// out_stall backs up the queue, then the front stages, then in_stall.
module spi_eeprom_transfer_sequencer
    import spi_eep_pkg::*;
#(
    parameter int PAGE_SIZE    = PAGE_SIZE_DEF,
    parameter int NUM_SECTIONS = NUM_SECTIONS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CMD_W-1:0]      command,
    input  logic [SECT_W-1:0]     section,
    input  logic [IDX_W-1:0]      index,
    input  logic [CNT_W-1:0]      count,
    input  logic                  bus_idle,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [ACTION_W-1:0]   action,
    output logic [OPCODE_W-1:0]   opcode,
    output logic [ADDR_OUT_W-1:0] address,
    output logic [LEN_W-1:0]      length,
    output logic [SPAN_W-1:0]     buffer_offset,
    output logic                  deselect_first
);

    cfg_t        cfg_reg;
    logic        push;
    front_item_t push_item;
    logic        queue_full;
    logic        pop;
    queue_head_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_addr <= MAX_ADDR_RESET;
            cfg_reg.section  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_ADDR)
            begin
                cfg_reg.max_addr <= cfg_data[SPAN_W-1:0];
            end
            for (int s = 0; s < NUM_SECT_REGS; s++)
            begin
                if (cfg_index == REG_SECTION_0 + CFG_IDX_W'(s))
                begin
                    cfg_reg.section[s] <= cfg_data;
                end
            end
        end
    end

    spi_eep_front #(
        .PAGE_SIZE    (PAGE_SIZE),
        .NUM_SECTIONS (NUM_SECTIONS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .section    (section),
        .index      (index),
        .count      (count),
        .bus_idle   (bus_idle),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    spi_eep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head      (head)
    );

    spi_eep_back #(
        .PAGE_SIZE (PAGE_SIZE),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .action         (action),
        .opcode         (opcode),
        .address        (address),
        .length         (length),
        .buffer_offset  (buffer_offset),
        .deselect_first (deselect_first)
    );

endmodule

/* rtl/spi_eep_checker.sv */
module spi_eep_checker
    import spi_eep_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [STATUS_W-1:0]   status,
    input logic [ACTION_W-1:0]   action,
    input logic [OPCODE_W-1:0]   opcode,
    input logic [ADDR_OUT_W-1:0] address,
    input logic [LEN_W-1:0]      length,
    input logic [SPAN_W-1:0]     buffer_offset,
    input logic                  deselect_first
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action) && $stable(status)
        && $stable(length) && $stable(buffer_offset) && $stable(address))
        else $error("result changed while stalled");

    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> action == ACT_NONE && opcode == OP_NONE)
        else $error("rejected transaction carries an action");

    a_header_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_HEADER |->
        deselect_first && (opcode == OP_WRITE || opcode == OP_READ) && length == '0)
        else $error("malformed header");

    a_data_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_DATA |-> !deselect_first && opcode == OP_NONE
        && address == '0)
        else $error("malformed data chunk");

endmodule

bind spi_eeprom_transfer_sequencer spi_eep_checker u_checker (.*);
